// File: design/fftshift_scatter_address_core_macros.svh
// Assertion macros used by the checker of the fftshift scatter address core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FFTSHIFT_SCATTER_ADDRESS_CORE_MACROS_SVH
`define FFTSHIFT_SCATTER_ADDRESS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fss_pkg.sv
// Package of the fftshift scatter address core: widths, register indexes,
// the configuration struct and the extent helper. Depends on nothing.
package fss_pkg;

  localparam int unsigned NumAxes             = 4;
  localparam int unsigned SizeW               = 13;
  localparam int unsigned AddrW               = 48;
  localparam int unsigned ExtMaxW             = 17;
  localparam int unsigned ApbAddrW            = 5;
  localparam int unsigned ApbDataW            = 32;
  localparam int unsigned RegIdxW             = ApbAddrW - 2;
  localparam int unsigned QueueDepth          = 4;

  localparam int unsigned MaxRankDefault      = 4;
  localparam int unsigned MaxAxisSizeDefault  = 4096;
  localparam int unsigned DataWidthDefault    = 64;

  localparam logic [RegIdxW-1:0] RegShiftForward = 3'd0;
  localparam logic [RegIdxW-1:0] RegAxisMask     = 3'd1;
  localparam logic [RegIdxW-1:0] RegSizeAxis0    = 3'd2;
  localparam logic [RegIdxW-1:0] RegSizeAxis1    = 3'd3;
  localparam logic [RegIdxW-1:0] RegSizeAxis2    = 3'd4;
  localparam logic [RegIdxW-1:0] RegSizeAxis3    = 3'd5;

  typedef struct packed {
    logic                             shift_forward;
    logic [NumAxes-1:0]               axis_mask;
    logic [NumAxes-1:0][SizeW-1:0]    size;
  } cfg_t;

  // Effective extent of one axis: zero counts as one, large sizes saturate,
  // and axes beyond the supported rank have extent one.
  function automatic logic [ExtMaxW-1:0] extent_of(input logic [SizeW-1:0] raw,
                                                   input int unsigned axis,
                                                   input int unsigned max_rank,
                                                   input int unsigned max_size);
    int unsigned n;
    n = 32'(raw);
    if (axis >= max_rank) begin
      n = 1;
    end else if (n == 0) begin
      n = 1;
    end else if (n > max_size) begin
      n = max_size;
    end
    return ExtMaxW'(n);
  endfunction

endpackage

// File: design/fss_regs.sv
// Configuration registers of the fftshift scatter address core behind an APB port.
// Depends on fss_pkg for the register indexes and the configuration struct.
module fss_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fss_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fss_pkg::ApbDataW-1:0]  pwdata,
  output logic [fss_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output fss_pkg::cfg_t                 cfg_o,
  output logic                          clear_o
);
  import fss_pkg::*;

  logic                          fwd_q;
  logic [NumAxes-1:0]            mask_q;
  logic [NumAxes-1:0][SizeW-1:0] size_q;
  logic [RegIdxW-1:0]            idx;
  logic                          wr;
  logic                          idx_ok;

  assign idx     = paddr[ApbAddrW-1:2];
  assign wr      = psel && penable && pwrite;
  assign idx_ok  = (idx <= RegSizeAxis3);
  assign clear_o = wr && idx_ok;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b1;
      mask_q <= '1;
      for (int k = 0; k < NumAxes; k++) begin
        size_q[k] <= SizeW'(1);
      end
    end else if (wr) begin
      case (idx)
        RegShiftForward: fwd_q     <= pwdata[0];
        RegAxisMask:     mask_q    <= pwdata[NumAxes-1:0];
        RegSizeAxis0:    size_q[0] <= pwdata[SizeW-1:0];
        RegSizeAxis1:    size_q[1] <= pwdata[SizeW-1:0];
        RegSizeAxis2:    size_q[2] <= pwdata[SizeW-1:0];
        RegSizeAxis3:    size_q[3] <= pwdata[SizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegShiftForward: prdata = ApbDataW'(fwd_q);
      RegAxisMask:     prdata = ApbDataW'(mask_q);
      RegSizeAxis0:    prdata = ApbDataW'(size_q[0]);
      RegSizeAxis1:    prdata = ApbDataW'(size_q[1]);
      RegSizeAxis2:    prdata = ApbDataW'(size_q[2]);
      RegSizeAxis3:    prdata = ApbDataW'(size_q[3]);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.shift_forward = fwd_q;
  assign cfg_o.axis_mask     = mask_q;
  assign cfg_o.size          = size_q;

endmodule

// File: design/fss_front.sv
// Front end of the fftshift scatter address core: coordinate odometer, rotation
// and end-of-tensor detection per element. Depends on fss_pkg.
module fss_front #(
  parameter int unsigned MAX_RANK      = fss_pkg::MaxRankDefault,
  parameter int unsigned MAX_AXIS_SIZE = fss_pkg::MaxAxisSizeDefault,
  parameter int unsigned DATA_WIDTH    = fss_pkg::DataWidthDefault,
  parameter int unsigned CW            = $clog2(MAX_AXIS_SIZE),
  parameter int unsigned ItemW         = DATA_WIDTH + fss_pkg::NumAxes * CW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fss_pkg::cfg_t         cfg_i,
  input  logic                  clear_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] elem_value_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [ItemW-1:0]      item_o
);
  import fss_pkg::*;

  localparam int unsigned EW = CW + 1;

  logic [NumAxes-1:0][CW-1:0] coord_q;
  logic [NumAxes-1:0][CW-1:0] coord_d;
  logic [NumAxes-1:0][CW-1:0] cur;
  logic [NumAxes-1:0][CW-1:0] rc;
  logic [NumAxes-1:0][EW-1:0] ext;
  logic [NumAxes-1:0]         is_max;
  logic [NumAxes-1:0]         carry;
  logic                       fire;

  always_comb begin
    logic [EW-1:0] c_ext;
    logic [EW-1:0] half;
    logic [EW-1:0] rot;
    logic [EW-1:0] sum;
    for (int k = 0; k < NumAxes; k++) begin
      ext[k] = EW'(extent_of(cfg_i.size[k], k, MAX_RANK, MAX_AXIS_SIZE));
      c_ext  = {1'b0, coord_q[k]};
      if (c_ext >= ext[k]) begin
        c_ext = '0;
      end
      cur[k]    = c_ext[CW-1:0];
      is_max[k] = (c_ext == ext[k] - EW'(1));
      half      = ext[k] >> 1;
      rot       = cfg_i.shift_forward ? half : ext[k] - half;
      sum       = c_ext + rot;
      if (sum >= ext[k]) begin
        sum = sum - ext[k];
      end
      rc[k] = cfg_i.axis_mask[k] ? sum[CW-1:0] : cur[k];
    end
  end

  always_comb begin
    carry[NumAxes-1] = 1'b1;
    for (int k = NumAxes - 2; k >= 0; k--) begin
      carry[k] = carry[k+1] & is_max[k+1];
    end
    for (int k = 0; k < NumAxes; k++) begin
      if (!carry[k]) begin
        coord_d[k] = cur[k];
      end else if (is_max[k]) begin
        coord_d[k] = '0;
      end else begin
        coord_d[k] = cur[k] + CW'(1);
      end
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;
  assign fire         = in_valid_i && push_ready_i;
  assign item_o       = {&is_max, rc, elem_value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else if (clear_i) begin
      coord_q <= '0;
    end else if (fire) begin
      coord_q <= coord_d;
    end
  end

endmodule

// File: design/fss_queue.sv
// Short register queue that decouples the front end from the address pipeline.
// Depends on fss_pkg for its default depth.
module fss_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = fss_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import fss_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PW-1:0]               wr_ptr_q;
  logic [PW-1:0]               rd_ptr_q;
  logic [PW:0]                 count_q;
  logic                        push;
  logic                        pop;

  assign push_ready_o = (count_q != (PW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

// File: design/fss_back.sv
// Back end of the fftshift scatter address core: three-stage multiply-add pipeline
// that folds rotated coordinates into a row-major address. Depends on fss_pkg.
module fss_back #(
  parameter int unsigned MAX_RANK      = fss_pkg::MaxRankDefault,
  parameter int unsigned MAX_AXIS_SIZE = fss_pkg::MaxAxisSizeDefault,
  parameter int unsigned DATA_WIDTH    = fss_pkg::DataWidthDefault,
  parameter int unsigned CW            = $clog2(MAX_AXIS_SIZE),
  parameter int unsigned ItemW         = DATA_WIDTH + fss_pkg::NumAxes * CW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fss_pkg::cfg_t              cfg_i,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  logic [ItemW-1:0]           item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [DATA_WIDTH-1:0]      out_value_o,
  output logic [fss_pkg::AddrW-1:0]  dest_addr_o,
  output logic                       tensor_end_o
);
  import fss_pkg::*;

  localparam int unsigned EW  = CW + 1;
  localparam int unsigned A1W = 2 * CW;
  localparam int unsigned A2W = 3 * CW;

  logic                       in_last;
  logic [NumAxes-1:0][CW-1:0] in_rc;
  logic [DATA_WIDTH-1:0]      in_value;
  logic [NumAxes-1:0][EW-1:0] ext;

  logic                  s1_v_q, s2_v_q, s3_v_q;
  logic                  adv1, adv2, adv3;
  logic [DATA_WIDTH-1:0] s1_value_q, s2_value_q, s3_value_q;
  logic                  s1_last_q, s2_last_q, s3_last_q;
  logic [A1W-1:0]        s1_addr_q, s1_addr_d;
  logic [A2W-1:0]        s2_addr_q, s2_addr_d;
  logic [AddrW-1:0]      s3_addr_q, s3_addr_d;
  logic [CW-1:0]         s1_c2_q, s1_c3_q, s2_c3_q;
  logic [CW+EW-1:0]      p1;
  logic [A1W+EW-1:0]     p2;
  logic [A2W+EW-1:0]     p3;

  assign {in_last, in_rc, in_value} = item_i;

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      ext[k] = EW'(extent_of(cfg_i.size[k], k, MAX_RANK, MAX_AXIS_SIZE));
    end
  end

  assign p1        = (CW+EW)'(in_rc[0]) * (CW+EW)'(ext[1]);
  assign s1_addr_d = A1W'(p1 + (CW+EW)'(in_rc[1]));
  assign p2        = (A1W+EW)'(s1_addr_q) * (A1W+EW)'(ext[2]);
  assign s2_addr_d = A2W'(p2 + (A1W+EW)'(s1_c2_q));
  assign p3        = (A2W+EW)'(s2_addr_q) * (A2W+EW)'(ext[3]);
  assign s3_addr_d = AddrW'(p3 + (A2W+EW)'(s2_c3_q));

  assign adv3        = !s3_v_q || out_ready_i;
  assign adv2        = !s2_v_q || adv3;
  assign adv1        = !s1_v_q || adv2;
  assign pop_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_q <= pop_valid_i;
      end
      if (adv2) begin
        s2_v_q <= s1_v_q;
      end
      if (adv3) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && pop_valid_i) begin
      s1_value_q <= in_value;
      s1_last_q  <= in_last;
      s1_addr_q  <= s1_addr_d;
      s1_c2_q    <= in_rc[2];
      s1_c3_q    <= in_rc[3];
    end
    if (adv2 && s1_v_q) begin
      s2_value_q <= s1_value_q;
      s2_last_q  <= s1_last_q;
      s2_addr_q  <= s2_addr_d;
      s2_c3_q    <= s1_c3_q;
    end
    if (adv3 && s2_v_q) begin
      s3_value_q <= s2_value_q;
      s3_last_q  <= s2_last_q;
      s3_addr_q  <= s3_addr_d;
    end
  end

  assign out_valid_o  = s3_v_q;
  assign out_value_o  = s3_value_q;
  assign dest_addr_o  = s3_addr_q;
  assign tensor_end_o = s3_last_q;

endmodule

// File: design/fftshift_scatter_address_core.sv
// Top level of the fftshift scatter address core: registers, front end, queue
// and address pipeline. Depends on fss_pkg and the fss_* modules.
//
// Elements enter in row-major order on the input channel (in_valid_i, in_ready_o,
// elem_value_i). Each one leaves on the output channel (out_valid_o, out_ready_i)
// with its unchanged bits, its fftshift or ifftshift destination address and a
// flag on the last element of the tensor. Shift direction, axis mask and the four
// axis extents are written over the APB port; any write to a defined register
// restarts the tensor at coordinate zero.
// Throughput is one element per cycle while the receiver does not stall. Each input
// transfer writes the queue, and the three multiply-add stages that fold the axes
// into an address then register the element in turn.
// When the receiver stalls, the pipeline holds its result, the stages behind it
// and then the four-entry queue keep taking elements until seven are in flight,
// after which in_ready_o drops.
// Reset empties the queue and pipeline, zeroes the coordinates and loads the
// register defaults: forward shift, all axes selected, every extent one.
module fftshift_scatter_address_core #(
  parameter int unsigned MAX_RANK      = fss_pkg::MaxRankDefault,
  parameter int unsigned MAX_AXIS_SIZE = fss_pkg::MaxAxisSizeDefault,
  parameter int unsigned DATA_WIDTH    = fss_pkg::DataWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fss_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fss_pkg::ApbDataW-1:0]  pwdata,
  output logic [fss_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [DATA_WIDTH-1:0]         elem_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [DATA_WIDTH-1:0]         out_value_o,
  output logic [fss_pkg::AddrW-1:0]     dest_addr_o,
  output logic                          tensor_end_o
);
  import fss_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_AXIS_SIZE);
  localparam int unsigned ItemW = DATA_WIDTH + NumAxes * CW + 1;

  cfg_t             cfg;
  logic             clear;
  logic             push_valid;
  logic             push_ready;
  logic [ItemW-1:0] push_item;
  logic             pop_valid;
  logic             pop_ready;
  logic [ItemW-1:0] pop_item;

  fss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  fss_front #(
    .MAX_RANK      (MAX_RANK),
    .MAX_AXIS_SIZE (MAX_AXIS_SIZE),
    .DATA_WIDTH    (DATA_WIDTH),
    .CW            (CW),
    .ItemW         (ItemW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clear_i      (clear),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .elem_value_i (elem_value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  fss_queue #(
    .WIDTH (ItemW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_item)
  );

  fss_back #(
    .MAX_RANK      (MAX_RANK),
    .MAX_AXIS_SIZE (MAX_AXIS_SIZE),
    .DATA_WIDTH    (DATA_WIDTH),
    .CW            (CW),
    .ItemW         (ItemW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .item_i       (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .dest_addr_o  (dest_addr_o),
    .tensor_end_o (tensor_end_o)
  );

endmodule

// File: design/fss_checker.sv
// Port-level checker of the fftshift scatter address core and its bind statement.
// Depends on fss_pkg and fftshift_scatter_address_core_macros.svh.
`include "fftshift_scatter_address_core_macros.svh"

module fss_checker #(
  parameter int unsigned DATA_WIDTH = fss_pkg::DataWidthDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [fss_pkg::ApbAddrW-1:0]  paddr,
  input logic [fss_pkg::ApbDataW-1:0]  pwdata,
  input logic [fss_pkg::ApbDataW-1:0]  prdata,
  input logic                          pready,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [DATA_WIDTH-1:0]         out_value_o,
  input logic [fss_pkg::AddrW-1:0]     dest_addr_o,
  input logic                          tensor_end_o
);
  import fss_pkg::*;

  `FSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_value_o) && $stable(dest_addr_o) && $stable(tensor_end_o), "Stalled result changed or vanished.")

  `FSS_ASSERT_IMPL(a_in_stall_cause, !in_ready_o, $past(out_valid_o && !out_ready_i), "Input stalled without an output stall in the previous cycle.")

  `FSS_ASSERT_IMPL(a_fwd_readback, (psel && penable && pwrite && pready && paddr[ApbAddrW-1:2] == RegShiftForward) ##1 (psel && !pwrite && paddr[ApbAddrW-1:2] == RegShiftForward), prdata[0] == $past(pwdata[0]), "Shift direction readback differs from the value written.")

endmodule

bind fftshift_scatter_address_core fss_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_fss_checker (.*);
